// File: rtl/encoder_rpm_pid_pwm_macros.svh
// Assertion macros used by the checker file of the encoder speed controller.
// Depends on nothing; take it in by a plain include.
`ifndef ENCODER_RPM_PID_PWM_MACROS_SVH
`define ENCODER_RPM_PID_PWM_MACROS_SVH

// Check a property at every rising edge while reset is low.
`define ERPP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising edge, reset cycles included.
`define ERPP_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/erpp_pkg.sv
// Shared widths, constants, codes and stage structs of the encoder speed controller.
// Depends on nothing; the RTL modules, the result and configuration interfaces and the testbench import it.
package erpp_pkg;

  // Default encoder resolution
  localparam int PPR_DEFAULT = 15;

  // Field and state widths
  localparam int CNT_W  = 14;
  localparam int MS_W   = 16;
  localparam int GAIN_W = 16;
  localparam int RPM_W  = 16;
  localparam int LIM_W  = 15;
  localparam int ERR_W  = 18;
  localparam int DIFF_W = 19;
  localparam int MAG_W  = 19;   // |count| * 60 / PPR for any PPR >= 1
  localparam int PID_W  = 32;
  localparam int PWM_W  = 8;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 16;

  // Arithmetic constants
  localparam int SEC_PER_MIN = 60;
  localparam int MAP_HI      = 100;
  localparam int MAP_LO      = -100;
  localparam int PWM_MAX     = 255;

  localparam logic signed [CNT_W-1:0] CNT_MAX = 14'sh1FFF;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 14'sh2000;

  // Register reset values
  localparam logic [GAIN_W-1:0]       RST_GAIN_PROP   = 16'd2560;
  localparam logic [GAIN_W-1:0]       RST_GAIN_INTEG  = 16'd512;
  localparam logic [GAIN_W-1:0]       RST_GAIN_DERIV  = 16'd26;
  localparam logic signed [RPM_W-1:0] RST_TARGET_RPM  = 16'sd100;
  localparam logic [MS_W-1:0]         RST_PERIOD_MS   = 16'd1000;
  localparam logic [LIM_W-1:0]        RST_INTEG_LIMIT = 15'd100;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_TARGET_RPM  = 3'd3,
    REG_PERIOD_MS   = 3'd4,
    REG_INTEG_LIMIT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]       gain_prop;
    logic [GAIN_W-1:0]       gain_integ;
    logic [GAIN_W-1:0]       gain_deriv;
    logic signed [RPM_W-1:0] target_rpm;
    logic [MS_W-1:0]         period_ms;
    logic [LIM_W-1:0]        integ_limit;
  } cfg_t;

  // Front stage: measurement snapshot taken when an update fires
  typedef struct packed {
    logic             valid;
    logic             fire;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } meas_t;

  // Last control stage: speed and PID output seen by this item
  typedef struct packed {
    logic                    valid;
    logic                    fire;
    logic signed [RPM_W-1:0] rpm;
    logic signed [PID_W-1:0] pid;
  } ctl_t;

  typedef struct packed {
    logic [PWM_W-1:0]        pwm_duty;
    logic signed [RPM_W-1:0] speed_rpm;
    logic signed [RPM_W-1:0] pid_result;
    logic                    updated;
  } res_t;

endpackage

// File: rtl/erpp_item_if.sv
// Input item channel: encoder edge or millisecond tick.
// Depends on nothing.
interface erpp_item_if;
  logic valid;
  logic ready;
  logic opcode;
  logic dir_level;

  modport source(output valid, output opcode, output dir_level, input ready);
  modport sink(input valid, input opcode, input dir_level, output ready);
endinterface

// File: rtl/erpp_result_if.sv
// Result channel: PWM duty, measured speed, PID output and update flag.
// Depends on erpp_pkg.
interface erpp_result_if;
  import erpp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [PWM_W-1:0]        pwm_duty;
  logic signed [RPM_W-1:0] speed_rpm;
  logic signed [RPM_W-1:0] pid_result;
  logic                    updated;

  modport source(output valid, output pwm_duty, output speed_rpm, output pid_result,
                 output updated, input ready);
  modport sink(input valid, input pwm_duty, input speed_rpm, input pid_result,
               input updated, output ready);
endinterface

// File: rtl/erpp_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on erpp_pkg.
interface erpp_cfg_if;
  import erpp_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/erpp_front.sv
// Front stage: pulse count with running rpm quotient, tick counter, update trigger.
// Depends on erpp_pkg.
module erpp_front #(
  parameter int PULSES_PER_REV = erpp_pkg::PPR_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     take,
  input  logic                     opcode,
  input  logic                     dir_level,
  input  logic [erpp_pkg::MS_W-1:0] period_ms,
  output erpp_pkg::meas_t          meas
);
  import erpp_pkg::*;

  // Remainder width, one extra bit for the sum before correction
  localparam int RW = $clog2(PULSES_PER_REV) + 1;
  localparam logic [RW:0]      PPR_R  = (RW+1)'(PULSES_PER_REV);
  localparam logic [RW:0]      STEP_R = (RW+1)'(SEC_PER_MIN % PULSES_PER_REV);
  localparam logic [MAG_W-1:0] STEP_Q = MAG_W'(SEC_PER_MIN / PULSES_PER_REV);
  localparam logic signed [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // |count| * 60 = mag * PPR + rem holds at all times
  logic signed [CNT_W-1:0] count, count_next;
  logic [MAG_W-1:0]        mag, mag_next;
  logic [RW-1:0]           rem, rem_next;
  logic [MS_W-1:0]         elapsed, elapsed_next, ms_inc;
  logic [RW:0]             rem_up, rem_dn;
  logic                    fire, hold, grow;

  // Next count, quotient and tick counter for the item on the port
  always_comb begin
    rem_up       = {1'b0, rem} + STEP_R;
    rem_dn       = {1'b0, rem} - STEP_R;
    ms_inc       = (elapsed == '1) ? elapsed : elapsed + 1'b1;
    fire         = 1'b0;
    hold         = dir_level ? (count == CNT_MAX) : (count == CNT_MIN);
    grow         = dir_level ? !count[CNT_W-1] : (count[CNT_W-1] || count == '0);
    count_next   = count;
    mag_next     = mag;
    rem_next     = rem;
    elapsed_next = elapsed;
    if (opcode == OP_TICK) begin
      fire         = ms_inc > period_ms;
      elapsed_next = fire ? '0 : ms_inc;
      if (fire) begin
        count_next = '0;
        mag_next   = '0;
        rem_next   = '0;
      end
    end else if (!hold) begin
      count_next = dir_level ? count + CNT_ONE : count - CNT_ONE;
      if (grow) begin
        if (rem_up >= PPR_R) begin
          rem_next = RW'(rem_up - PPR_R);
          mag_next = mag + STEP_Q + 1'b1;
        end else begin
          rem_next = RW'(rem_up);
          mag_next = mag + STEP_Q;
        end
      end else begin
        if ({1'b0, rem} < STEP_R) begin
          rem_next = RW'(rem_dn + PPR_R);
          mag_next = mag - STEP_Q - 1'b1;
        end else begin
          rem_next = RW'(rem_dn);
          mag_next = mag - STEP_Q;
        end
      end
    end
  end

  // Advance state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      mag     <= '0;
      rem     <= '0;
      elapsed <= '0;
    end else if (take) begin
      count   <= count_next;
      mag     <= mag_next;
      rem     <= rem_next;
      elapsed <= elapsed_next;
    end
  end

  // Stage register: valid flag, and a snapshot taken before the count is cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      meas.valid <= 1'b0;
    end else if (adv) begin
      meas.valid <= take;
    end
    if (take) begin
      meas.fire <= fire;
      meas.neg  <= count[CNT_W-1];
      meas.mag  <= mag;
    end
  end

endmodule

// File: rtl/erpp_pid.sv
// PID pipeline: rpm and error, gain products, integral clamp, output sum and clamp.
// Depends on erpp_pkg.
module erpp_pid (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  erpp_pkg::cfg_t  cfg,
  input  erpp_pkg::meas_t meas,
  output erpp_pkg::ctl_t  ctl
);
  import erpp_pkg::*;

  localparam int P_W    = GAIN_W + 1 + ERR_W;
  localparam int D_W    = GAIN_W + 1 + DIFF_W;
  localparam int INT_W  = LIM_W + 8 + 1;
  localparam int ISUM_W = P_W + 1;
  localparam int PS_W   = D_W + 1;
  localparam int TOT_W  = PS_W + 1;

  localparam logic [MAG_W-1:0] MAG_POS_MAX = MAG_W'(32767);
  localparam logic [MAG_W-1:0] MAG_NEG_MAX = MAG_W'(32768);
  localparam logic signed [RPM_W-1:0] RPM_HI = 16'sh7FFF;
  localparam logic signed [RPM_W-1:0] RPM_LO = 16'sh8000;
  localparam logic signed [TOT_W-1:0] TOT_HI = TOT_W'(32'sh7FFF_FFFF);
  localparam logic signed [TOT_W-1:0] TOT_LO = TOT_W'(32'sh8000_0000);

  // Controller state, each owned by one stage
  logic signed [RPM_W-1:0] last_rpm;
  logic signed [ERR_W-1:0] prev_error;
  logic signed [INT_W-1:0] integ_acc;
  logic signed [PID_W-1:0] pid_out;

  // Stage 2: rpm, error, error step
  logic [MAG_W-1:0]         neg_mag;
  logic signed [RPM_W-1:0]  rpm_meas;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic                     v2, f2;
  logic signed [RPM_W-1:0]  rpm2;
  logic signed [ERR_W-1:0]  err2;
  logic signed [DIFF_W-1:0] diff2;

  always_comb begin
    neg_mag = '0 - meas.mag;
    if (meas.neg) begin
      rpm_meas = (meas.mag > MAG_NEG_MAX) ? RPM_LO : $signed(neg_mag[RPM_W-1:0]);
    end else begin
      rpm_meas = (meas.mag > MAG_POS_MAX) ? RPM_HI : $signed(meas.mag[RPM_W-1:0]);
    end
    err  = ERR_W'(cfg.target_rpm) - ERR_W'(rpm_meas);
    diff = DIFF_W'(err) - DIFF_W'(prev_error);
  end

  // Stage 3: gain products
  logic                    v3, f3;
  logic signed [RPM_W-1:0] rpm3;
  logic signed [P_W-1:0]   pprod3, iprod3;
  logic signed [D_W-1:0]   dprod3;

  // Stage 4: integral update and P + D
  logic signed [ISUM_W-1:0] isum, lim_s, integ_new;
  logic                     v4, f4;
  logic signed [RPM_W-1:0]  rpm4;
  logic signed [PS_W-1:0]   psum4;
  logic signed [INT_W-1:0]  integ4;

  always_comb begin
    isum  = ISUM_W'(integ_acc) + ISUM_W'(iprod3);
    lim_s = $signed({{(ISUM_W-LIM_W-8){1'b0}}, cfg.integ_limit, 8'b0});
    if (isum > lim_s) begin
      integ_new = lim_s;
    end else if (isum < -lim_s) begin
      integ_new = -lim_s;
    end else begin
      integ_new = isum;
    end
  end

  // Stage 5: output sum and saturation
  logic signed [TOT_W-1:0] tot;
  logic signed [PID_W-1:0] pid_sat, pid_val;

  always_comb begin
    tot = TOT_W'(psum4) + TOT_W'(integ4);
    if (tot > TOT_HI) begin
      pid_sat = TOT_HI[PID_W-1:0];
    end else if (tot < TOT_LO) begin
      pid_sat = TOT_LO[PID_W-1:0];
    end else begin
      pid_sat = tot[PID_W-1:0];
    end
    pid_val = f4 ? pid_sat : pid_out;
  end

  // Stage valid flags, output stage and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      ctl.valid  <= 1'b0;
      last_rpm   <= '0;
      prev_error <= '0;
      integ_acc  <= '0;
      pid_out    <= '0;
    end else if (adv) begin
      v2        <= meas.valid;
      v3        <= v2;
      v4        <= v3;
      ctl.valid <= v4;
      ctl.fire  <= f4;
      ctl.rpm   <= rpm4;
      ctl.pid   <= pid_val;
      if (meas.valid && meas.fire) begin
        last_rpm   <= rpm_meas;
        prev_error <= err;
      end
      if (v3 && f3) begin
        integ_acc <= INT_W'(integ_new);
      end
      if (v4 && f4) begin
        pid_out <= pid_sat;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      f2       <= meas.fire;
      rpm2     <= meas.fire ? rpm_meas : last_rpm;
      err2     <= err;
      diff2    <= diff;
      f3       <= f2;
      rpm3     <= rpm2;
      pprod3   <= $signed({1'b0, cfg.gain_prop}) * err2;
      iprod3   <= $signed({1'b0, cfg.gain_integ}) * err2;
      dprod3   <= $signed({1'b0, cfg.gain_deriv}) * diff2;
      f4       <= f3;
      rpm4     <= rpm3;
      psum4    <= PS_W'(pprod3) + PS_W'(dprod3);
      integ4   <= INT_W'(integ_new);
    end
  end

endmodule

// File: rtl/erpp_map.sv
// Output mapping: integer part of the PID output and its PWM duty.
// Depends on erpp_pkg.
module erpp_map (
  input  erpp_pkg::ctl_t ctl,
  output erpp_pkg::res_t res
);
  import erpp_pkg::*;

  localparam int WHOLE_W = PID_W - 8;
  localparam int X_W     = 2 * PWM_W - 3;
  localparam int RECIP   = 10486;          // ceil(2^18 / 25)
  localparam int RECIP_SH = 18;
  localparam int PROD_W  = X_W + 14;

  localparam logic signed [WHOLE_W-1:0] W_HI   = WHOLE_W'(MAP_HI);
  localparam logic signed [WHOLE_W-1:0] W_LO   = WHOLE_W'(MAP_LO);
  localparam logic signed [WHOLE_W-1:0] R_HI   = WHOLE_W'(32767);
  localparam logic signed [WHOLE_W-1:0] R_LO   = WHOLE_W'(-32768);
  localparam logic [PWM_W-1:0]          PWM_TOP = PWM_W'(PWM_MAX);

  logic signed [WHOLE_W-1:0] whole, shifted;
  logic                      round_up;
  logic [PWM_W-1:0]          v;
  logic [2*PWM_W-1:0]        span;
  logic [X_W-1:0]            x;
  logic [PROD_W-1:0]         prod;

  always_comb begin
    // Integer part, rounded toward zero
    shifted  = $signed(ctl.pid[PID_W-1:8]);
    round_up = ctl.pid[PID_W-1] && (ctl.pid[7:0] != '0);
    whole    = shifted + WHOLE_W'(round_up);

    // (whole + 100) * 255 / 200: times 255, shift by 3, then divide by 25
    v    = PWM_W'(whole - W_LO);
    span = {v, {PWM_W{1'b0}}} - {{PWM_W{1'b0}}, v};
    x    = span[2*PWM_W-1:3];
    prod = PROD_W'(x) * PROD_W'(RECIP);

    if (whole <= W_LO) begin
      res.pwm_duty = '0;
    end else if (whole >= W_HI) begin
      res.pwm_duty = PWM_TOP;
    end else begin
      res.pwm_duty = prod[RECIP_SH +: PWM_W];
    end

    if (whole > R_HI) begin
      res.pid_result = R_HI[RPM_W-1:0];
    end else if (whole < R_LO) begin
      res.pid_result = R_LO[RPM_W-1:0];
    end else begin
      res.pid_result = whole[RPM_W-1:0];
    end

    res.speed_rpm = ctl.rpm;
    res.updated   = ctl.fire;
  end

endmodule

// File: rtl/erpp_skid.sv
// Output register with a one-entry skid stage; stalls the pipeline when the skid is full.
// Depends on erpp_pkg and erpp_result_if.
module erpp_skid (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  erpp_pkg::res_t        in_data,
  output logic                  adv,
  erpp_result_if.source         result
);
  import erpp_pkg::*;

  logic out_valid, skid_valid;
  res_t out_data, skid_data;

  assign adv = !skid_valid;

  // Hold state of the two entries
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (!out_valid || result.ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Move payloads: skid drains first, new items go to the free entry
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result.ready) begin
        out_data <= skid_data;
      end
    end else if (in_valid) begin
      if (!out_valid || result.ready) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.pwm_duty   = out_data.pwm_duty;
  assign result.speed_rpm  = out_data.speed_rpm;
  assign result.pid_result = out_data.pid_result;
  assign result.updated    = out_data.updated;

endmodule

// File: rtl/encoder_rpm_pid_pwm.sv
// Encoder speed measurement with a PID speed controller and PWM mapping.
// Items on "item" are encoder A rising edges (opcode 0, B level in dir_level)
// or one-millisecond ticks (opcode 1). Every accepted item yields one result
// on "result": PWM duty, last measured rpm, integer PID output and a flag that
// says whether this item fired a measurement and PID step.
// Registers are written on "cfg" (index 0..5: proportional, integral and
// derivative gains in Q8.8, target rpm, period in ms, integral limit);
// unknown indexes are ignored and cfg.ready is always high.
// Each result is registered in the front stage, the PID stages and the output register.
// Throughput: one item per cycle while the skid stage is empty; the pipeline of
// front stage, four PID stages and the output register advances as one, the
// integral and output state each closing a loop within their own stage.
// When the receiver stalls, the output register holds its result and one
// more result lands in the skid stage; item.ready then drops until it drains.
// Synchronous reset loads the register defaults, clears count, tick counter
// and controller state, and empties the pipeline.
// Depends on erpp_pkg, the channel interfaces and the erpp_* submodules.
module encoder_rpm_pid_pwm #(
  parameter int PULSES_PER_REV = erpp_pkg::PPR_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  erpp_item_if.sink     item,
  erpp_result_if.source result,
  erpp_cfg_if.sink      cfg
);
  import erpp_pkg::*;

  cfg_t  regs;
  meas_t meas;
  ctl_t  ctl;
  res_t  res;
  logic  adv, take;

  assign cfg.ready  = 1'b1;
  assign item.ready = adv;
  assign take       = item.valid && adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_prop   <= RST_GAIN_PROP;
      regs.gain_integ  <= RST_GAIN_INTEG;
      regs.gain_deriv  <= RST_GAIN_DERIV;
      regs.target_rpm  <= RST_TARGET_RPM;
      regs.period_ms   <= RST_PERIOD_MS;
      regs.integ_limit <= RST_INTEG_LIMIT;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GAIN_PROP:   regs.gain_prop   <= cfg.data;
        REG_GAIN_INTEG:  regs.gain_integ  <= cfg.data;
        REG_GAIN_DERIV:  regs.gain_deriv  <= cfg.data;
        REG_TARGET_RPM:  regs.target_rpm  <= $signed(cfg.data);
        REG_PERIOD_MS:   regs.period_ms   <= cfg.data;
        REG_INTEG_LIMIT: regs.integ_limit <= cfg.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  erpp_front #(
    .PULSES_PER_REV(PULSES_PER_REV)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .take      (take),
    .opcode    (item.opcode),
    .dir_level (item.dir_level),
    .period_ms (regs.period_ms),
    .meas      (meas)
  );

  erpp_pid u_pid (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .cfg  (regs),
    .meas (meas),
    .ctl  (ctl)
  );

  erpp_map u_map (
    .ctl (ctl),
    .res (res)
  );

  erpp_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ctl.valid),
    .in_data  (res),
    .adv      (adv),
    .result   (result)
  );

endmodule

// File: rtl/erpp_checker.sv
// Port-level checks of the encoder speed controller, bound to the top level.
// Depends on encoder_rpm_pid_pwm_macros.svh.
`include "encoder_rpm_pid_pwm_macros.svh"

module erpp_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [7:0]         pwm_duty,
  input logic signed [15:0] speed_rpm,
  input logic signed [15:0] pid_result,
  input logic               updated
);

  // A stalled result holds still
  `ERPP_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(pwm_duty) && $stable(speed_rpm) && $stable(pid_result) && $stable(updated), "stalled result changed")

  // Back-pressure on items only while a result waits
  `ERPP_ASSERT(a_stall_cause, clk, rst, !item_ready |-> res_valid, "item stalled with no result pending")

  // Duty saturates at the ends of the PID range
  `ERPP_ASSERT(a_pwm_low, clk, rst, res_valid && (pid_result <= -16'sd100) |-> pwm_duty == 8'd0, "duty not zero at low PID output")
  `ERPP_ASSERT(a_pwm_high, clk, rst, res_valid && (pid_result >= 16'sd100) |-> pwm_duty == 8'hFF, "duty not full at high PID output")

  // Reset empties the output
  `ERPP_ASSERT_RST(a_rst_empty, clk, rst |=> !res_valid, "result valid after reset")

endmodule

bind encoder_rpm_pid_pwm erpp_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .pwm_duty   (result.pwm_duty),
  .speed_rpm  (result.speed_rpm),
  .pid_result (result.pid_result),
  .updated    (result.updated)
);

// File: verif/tb_encoder_rpm_pid_pwm.sv
// Self-checking testbench for encoder_rpm_pid_pwm: edge/tick items in, one result per item out.
// A cycle-free speed/PID predictor tracks count, tick counter and controller state per transfer.
// Depends on erpp_pkg, the erpp_item_if/erpp_result_if/erpp_cfg_if interfaces and the RTL top.
module tb_encoder_rpm_pid_pwm;
  import erpp_pkg::*;

  localparam int PPR            = PPR_DEFAULT;
  localparam int RST_CYCLES     = 7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int STALL_CYCLES   = 80;
  localparam int PHASE_ITEMS    = 110;
  localparam int PHASES_PER_MODE = 4;
  localparam int SWEEP_EDGES    = 16;
  localparam int SWEEP_TICKS    = 8;

  localparam logic [IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_B = 3'd7;

  localparam longint I32_MAX = (longint'(1) <<< 31) - 1;
  localparam longint I32_MIN = -(longint'(1) <<< 31);
  localparam longint I16_MAX = 32767;
  localparam longint I16_MIN = -32768;
  localparam res_t   NO_PIN  = '0;

  typedef struct {
    logic             to_reg;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
    op_t              op;
    logic             dir;
    logic             pinned;
    res_t             want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  erpp_item_if   item_bus();
  erpp_result_if result_bus();
  erpp_cfg_if    cfg_bus();

  encoder_rpm_pid_pwm #(.PULSES_PER_REV(PPR)) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always #2 clk = ~clk;

  // Speed/PID predictor state and register copy
  cfg_t                    ctl_regs;
  logic signed [CNT_W-1:0] enc_count;
  logic [MS_W-1:0]         ms_count;
  logic signed [PID_W-1:0] integ_q8;
  logic signed [ERR_W-1:0] last_err;
  logic signed [PID_W-1:0] pid_q8;
  logic signed [RPM_W-1:0] meas_rpm;

  res_t pending_results[$];
  res_t last_pred;
  plan_row_t plan_rows[$];

  int fail_count     = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int stall_requests = 0;
  int stall_served   = 0;
  int stall_left     = 0;

  function automatic longint clamp_l(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Advance the predictor by one item and return the result it owes
  function automatic res_t predict_result(op_t op, logic dir);
    longint rpm, err, lim, p, d, whole, duty;
    logic   fired;
    res_t   r;
    fired = 1'b0;
    if (op == OP_EDGE) begin
      if (dir) begin
        if (enc_count != CNT_MAX) enc_count = enc_count + CNT_W'(1);
      end else if (enc_count != CNT_MIN) begin
        enc_count = enc_count - CNT_W'(1);
      end
    end else begin
      if (ms_count != '1) ms_count = ms_count + 1'b1;
      if (ms_count > ctl_regs.period_ms) begin
        ms_count = '0;
        fired    = 1'b1;
        rpm = clamp_l(longint'(enc_count) * SEC_PER_MIN / PPR, I16_MIN, I16_MAX);
        meas_rpm = RPM_W'(rpm);
        err = longint'(ctl_regs.target_rpm) - rpm;
        p   = longint'(ctl_regs.gain_prop) * err;
        lim = longint'(ctl_regs.integ_limit) * 256;
        integ_q8 = PID_W'(clamp_l(longint'(integ_q8) + longint'(ctl_regs.gain_integ) * err,
                                  -lim, lim));
        d = longint'(ctl_regs.gain_deriv) * (err - longint'(last_err));
        last_err  = ERR_W'(err);
        pid_q8    = PID_W'(clamp_l(p + longint'(integ_q8) + d, I32_MIN, I32_MAX));
        enc_count = '0;
      end
    end
    whole = longint'(pid_q8) / 256;
    duty  = clamp_l((whole + MAP_HI) * PWM_MAX / (MAP_HI - MAP_LO), 0, PWM_MAX);
    r.pwm_duty   = PWM_W'(duty);
    r.speed_rpm  = meas_rpm;
    r.pid_result = RPM_W'(clamp_l(whole, I16_MIN, I16_MAX));
    r.updated    = fired;
    return r;
  endfunction

  function automatic void load_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_GAIN_PROP:   ctl_regs.gain_prop   = data;
      REG_GAIN_INTEG:  ctl_regs.gain_integ  = data;
      REG_GAIN_DERIV:  ctl_regs.gain_deriv  = data;
      REG_TARGET_RPM:  ctl_regs.target_rpm  = data;
      REG_PERIOD_MS:   ctl_regs.period_ms   = data;
      REG_INTEG_LIMIT: ctl_regs.integ_limit = data[LIM_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return GAIN_W'($urandom_range(4095));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic plan_row_t item_row(op_t op, logic dir);
    plan_row_t r;
    r = '{to_reg: 1'b0, idx: '0, data: '0, op: op, dir: dir, pinned: 1'b0, want: NO_PIN};
    return r;
  endfunction

  function automatic plan_row_t pinned_row(op_t op, logic dir, int duty, int rpm, int pid,
                                           logic upd);
    plan_row_t r;
    r = item_row(op, dir);
    r.pinned          = 1'b1;
    r.want.pwm_duty   = PWM_W'(duty);
    r.want.speed_rpm  = RPM_W'(rpm);
    r.want.pid_result = RPM_W'(pid);
    r.want.updated    = upd;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    plan_row_t r;
    r = item_row(OP_EDGE, 1'b0);
    r.to_reg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then log what it must produce
  task automatic push_item(input op_t op, input logic dir, input logic pinned, input res_t want);
    res_t model_res;
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid     <= 1'b1;
    item_bus.opcode    <= op;
    item_bus.dir_level <= dir;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    model_res = predict_result(op, dir);
    last_pred = model_res;
    pending_results.push_back(pinned ? want : model_res);
  endtask

  // Write one register once the block has drained; keep valid up for a following write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                           input logic keep);
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    load_reg(idx, data);
    if (!keep) cfg_bus.valid <= 1'b0;
  endtask

  task automatic tick_until_update();
    do begin
      push_item(OP_TICK, 1'($urandom_range(1)), 1'b0, NO_PIN);
    end while (!last_pred.updated);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      result_bus.ready <= 1'b0;
      stall_left       <= stall_left - 1;
    end else if (stall_served != stall_requests) begin
      stall_served     <= stall_requests;
      stall_left       <= STALL_CYCLES;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every result transfer with the oldest pending prediction
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no pending prediction");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_bus.pwm_duty !== want.pwm_duty) begin
          $error("pwm_duty: expected %0d, actual %0d", want.pwm_duty, result_bus.pwm_duty);
          fail_count++;
        end
        if (result_bus.speed_rpm !== want.speed_rpm) begin
          $error("speed_rpm: expected %0d, actual %0d", want.speed_rpm, result_bus.speed_rpm);
          fail_count++;
        end
        if (result_bus.pid_result !== want.pid_result) begin
          $error("pid_result: expected %0d, actual %0d", want.pid_result,
                 result_bus.pid_result);
          fail_count++;
        end
        if (result_bus.updated !== want.updated) begin
          $error("updated: expected %0d, actual %0d", want.updated, result_bus.updated);
          fail_count++;
        end
      end
    end
  end

  // Abort when no channel has moved a transfer for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int            sent, burst;
    logic          fwd;
    logic [15:0]   target, lim_data;
    logic [LIM_W-1:0] lim;
    logic [MS_W-1:0]  period;

    rst                = 1'b1;
    item_bus.valid     = 1'b0;
    item_bus.opcode    = OP_EDGE;
    item_bus.dir_level = 1'b0;
    result_bus.ready   = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = '0;
    cfg_bus.data       = '0;

    ctl_regs = '{gain_prop: RST_GAIN_PROP, gain_integ: RST_GAIN_INTEG,
                 gain_deriv: RST_GAIN_DERIV, target_rpm: RST_TARGET_RPM,
                 period_ms: RST_PERIOD_MS, integ_limit: RST_INTEG_LIMIT};
    enc_count = '0;
    ms_count  = '0;
    integ_q8  = '0;
    last_err  = '0;
    pid_q8    = '0;
    meas_rpm  = '0;

    // Directed plan: reset values, zero period, saturated PID both ways,
    // zero gains, ignored register indexes, dropped limit bit, period of one
    plan_rows.push_back(pinned_row(OP_EDGE, 1'b1, 127, 0, 0, 1'b0));
    plan_rows.push_back(pinned_row(OP_EDGE, 1'b0, 127, 0, 0, 1'b0));
    plan_rows.push_back(pinned_row(OP_TICK, 1'b0, 127, 0, 0, 1'b0));
    plan_rows.push_back(reg_row(REG_PERIOD_MS, 16'd0));
    plan_rows.push_back(item_row(OP_TICK, 1'b1));
    plan_rows.push_back(item_row(OP_EDGE, 1'b1));
    plan_rows.push_back(item_row(OP_EDGE, 1'b1));
    plan_rows.push_back(item_row(OP_EDGE, 1'b1));
    plan_rows.push_back(item_row(OP_TICK, 1'b0));
    plan_rows.push_back(reg_row(REG_GAIN_PROP, 16'hFFFF));
    plan_rows.push_back(reg_row(REG_GAIN_INTEG, 16'hFFFF));
    plan_rows.push_back(reg_row(REG_GAIN_DERIV, 16'hFFFF));
    plan_rows.push_back(reg_row(REG_TARGET_RPM, 16'h8000));
    plan_rows.push_back(reg_row(REG_INTEG_LIMIT, 16'h7FFF));
    plan_rows.push_back(item_row(OP_EDGE, 1'b0));
    plan_rows.push_back(item_row(OP_EDGE, 1'b0));
    plan_rows.push_back(item_row(OP_TICK, 1'b0));
    plan_rows.push_back(reg_row(REG_TARGET_RPM, 16'h7FFF));
    plan_rows.push_back(item_row(OP_TICK, 1'b1));
    plan_rows.push_back(reg_row(REG_GAIN_PROP, 16'h0000));
    plan_rows.push_back(reg_row(REG_GAIN_INTEG, 16'h0000));
    plan_rows.push_back(reg_row(REG_GAIN_DERIV, 16'h0000));
    plan_rows.push_back(reg_row(REG_INTEG_LIMIT, 16'h8000));
    plan_rows.push_back(reg_row(REG_TARGET_RPM, 16'h0000));
    plan_rows.push_back(pinned_row(OP_TICK, 1'b0, 127, 0, 0, 1'b1));
    plan_rows.push_back(reg_row(IDX_SPARE_A, 16'hFFFF));
    plan_rows.push_back(reg_row(IDX_SPARE_B, 16'hFFFF));
    plan_rows.push_back(pinned_row(OP_TICK, 1'b1, 127, 0, 0, 1'b1));
    plan_rows.push_back(reg_row(REG_PERIOD_MS, 16'd1));
    plan_rows.push_back(pinned_row(OP_TICK, 1'b0, 127, 0, 0, 1'b0));
    plan_rows.push_back(pinned_row(OP_TICK, 1'b1, 127, 0, 0, 1'b1));
    plan_rows.push_back(pinned_row(OP_EDGE, 1'b1, 127, 0, 0, 1'b0));

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 21;
    recv_idle_pct = 57;

    // Walk the directed plan
    for (int i = 0; i < plan_rows.size(); i++) begin
      if (plan_rows[i].to_reg)
        write_reg(plan_rows[i].idx, plan_rows[i].data,
                  (i + 1 < plan_rows.size()) && plan_rows[i + 1].to_reg);
      else
        push_item(plan_rows[i].op, plan_rows[i].dir, plan_rows[i].pinned, plan_rows[i].want);
    end

    // Random phases: receiver idles most, then sender idles most, then neither
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 21 : ((mode == 1) ? 57 : 0);
      recv_idle_pct = (mode == 0) ? 57 : ((mode == 1) ? 21 : 0);
      for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
        // New register setting with a short period so updates come often
        case ($urandom_range(3))
          0: target = 16'h8000;
          1: target = 16'h7FFF;
          2: target = 16'($urandom_range(400)) - 16'd200;
          default: target = 16'($urandom);
        endcase
        case ($urandom_range(3))
          0: lim = '0;
          1: lim = '1;
          2: lim = LIM_W'($urandom_range(400));
          default: lim = LIM_W'($urandom);
        endcase
        lim_data = {1'($urandom_range(1)), lim};
        period   = ($urandom_range(7) == 0) ? MS_W'($urandom_range(40, 9))
                                             : MS_W'($urandom_range(8));
        write_reg(REG_GAIN_PROP, pick_gain(), 1'b1);
        write_reg(REG_GAIN_INTEG, pick_gain(), 1'b1);
        write_reg(REG_GAIN_DERIV, pick_gain(), 1'b1);
        write_reg(REG_TARGET_RPM, target, 1'b1);
        write_reg(REG_PERIOD_MS, period, 1'b1);
        write_reg(REG_INTEG_LIMIT, lim_data, 1'b0);

        // Hold off the receiver once with the sender going full rate
        if (mode == 2 && ph == 0) stall_requests <= stall_requests + 1;

        // Mostly edge bursts in one direction closed by a tick, some noise
        sent = 0;
        while (sent < PHASE_ITEMS) begin
          if ($urandom_range(9) == 0) begin
            push_item(op_t'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, NO_PIN);
            sent++;
          end else begin
            burst = $urandom_range(12);
            fwd   = 1'($urandom_range(1));
            repeat (burst)
              push_item(OP_EDGE, ($urandom_range(9) == 0) ? !fwd : fwd, 1'b0, NO_PIN);
            push_item(OP_TICK, 1'($urandom_range(1)), 1'b0, NO_PIN);
            sent += burst + 1;
          end
        end
      end
    end

    // Edge runs both ways at a short period
    write_reg(REG_PERIOD_MS, 16'd2, 1'b0);
    tick_until_update();
    repeat (SWEEP_EDGES) push_item(OP_EDGE, 1'b1, 1'b0, NO_PIN);
    tick_until_update();
    repeat (SWEEP_EDGES) push_item(OP_EDGE, 1'b0, 1'b0, NO_PIN);
    tick_until_update();

    // The longest period holds off updates, then a short one fires at once
    write_reg(REG_PERIOD_MS, 16'hFFFF, 1'b0);
    repeat (SWEEP_TICKS) push_item(OP_TICK, 1'($urandom_range(1)), 1'b0, NO_PIN);
    write_reg(REG_PERIOD_MS, 16'd3, 1'b0);
    tick_until_update();

    // Drain and let any stray result show up
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
